@@ src/phm_pkg.sv @@
// ----------------------------------------------------------------------------
// phm_pkg: shared types and constants for the pointer keyed hash map
// opcodes, status codes, payload structs and the fnv-1a constants
// ----------------------------------------------------------------------------
package phm_pkg;

  localparam int unsigned BucketsDef    = 1024;
  localparam int unsigned NodesDef      = 1024;
  localparam int unsigned HandleBitsDef = 32;
  localparam int unsigned KeyBytes      = 8;

  localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] FnvMult  = 64'h00000100000001b3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NULL    = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key_address;
    logic [31:0] handle;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] found_handle;
    logic [1:0]  status;
  } out_item_t;

  // xor half of one fnv-1a byte step; phm_front does the multiply in partial products
  function automatic logic [63:0] fnv_xor(input logic [63:0] h, input logic [7:0] b);
    fnv_xor = h ^ {56'd0, b};
  endfunction

endpackage

@@ src/phm_front.sv @@
// ----------------------------------------------------------------------------
// phm_front: command front end
// accepts items, hashes the key one byte at a time (xor, then multiply), reduces
// the hash to a bucket index and pushes the item with its bucket to the queue
// ----------------------------------------------------------------------------
module phm_front #(
  parameter int unsigned Buckets = phm_pkg::BucketsDef,
  localparam int unsigned BW = (Buckets > 1) ? $clog2(Buckets) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  phm_pkg::in_item_t in_item_i,
  output logic             q_valid_o,
  input  logic             q_stall_i,
  output phm_pkg::in_item_t q_item_o,
  output logic [BW-1:0]    q_bucket_o
);

  // bucket reduction: the 64-bit hash is taken as four 16-bit digits, high
  // digit first; each step divides (rem << 16 | digit) by the bucket count
  // with an exact reciprocal multiply, then subtracts quotient * count
  localparam int unsigned ModShift = 32 + $clog2(Buckets);
  localparam logic [63:0] ModRecip64 =
    ((64'd1 << ModShift) + 64'(Buckets) - 64'd1) / 64'(Buckets);
  localparam logic [32:0] ModRecip  = ModRecip64[32:0];
  localparam logic [16:0] ModDiv    = 17'(Buckets);
  localparam logic [2:0]  LastDigit = 3'd3;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_XOR  = 6'b000010,
    F_MUL  = 6'b000100,
    F_MODA = 6'b001000,
    F_MODB = 6'b010000,
    F_PUSH = 6'b100000
  } fstate_e;

  fstate_e state_q, state_d;
  phm_pkg::in_item_t item_q;
  logic [63:0] h_q, h_d;
  logic [2:0]  byte_q, byte_d;
  // partial products of the 64x64 multiply by the sparse fnv prime
  logic [63:0] p_lo_q, p_hi_q;
  logic [63:0] hx;
  // running remainder and reciprocal product of the bucket reduction
  logic [15:0] r_q, r_d;
  logic [64:0] prod_q;
  logic [31:0] mod_v, mod_quo, mod_rem;
  logic [48:0] mod_qb;

  assign in_stall_o = (state_q != F_IDLE);
  assign q_valid_o  = (state_q == F_PUSH);
  assign q_item_o   = item_q;
  assign q_bucket_o = r_q[BW-1:0];

  assign mod_v   = {r_q, h_q[63:48]};
  assign mod_quo = 32'(prod_q >> ModShift);
  assign mod_qb  = {17'd0, mod_quo} * {32'd0, ModDiv};
  assign mod_rem = mod_v - mod_qb[31:0];

  always_comb begin
    hx      = phm_pkg::fnv_xor(h_q, item_q.key_address[8*byte_q +: 8]);
    state_d = state_q;
    h_d     = h_q;
    byte_d  = byte_q;
    r_d     = r_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          state_d = F_XOR;
          h_d     = phm_pkg::FnvBasis;
          byte_d  = '0;
        end
      end
      F_XOR:  state_d = F_MUL;
      F_MUL: begin
        h_d = p_lo_q + p_hi_q;
        if (byte_q == 3'(phm_pkg::KeyBytes - 1)) begin
          byte_d  = '0;
          r_d     = '0;
          state_d = F_MODA;
        end else begin
          byte_d  = byte_q + 3'd1;
          state_d = F_XOR;
        end
      end
      F_MODA: state_d = F_MODB;
      F_MODB: begin
        r_d = mod_rem[15:0];
        h_d = {h_q[47:0], 16'd0};
        if (byte_q == LastDigit) begin
          state_d = F_PUSH;
        end else begin
          byte_d  = byte_q + 3'd1;
          state_d = F_MODA;
        end
      end
      F_PUSH: if (!q_stall_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) item_q <= in_item_i;
    h_q    <= h_d;
    byte_q <= byte_d;
    r_q    <= r_d;
    if (state_q == F_XOR) begin
      // h*prime = h*0x1b3 + (h << 40)
      p_lo_q <= hx * 64'h1b3;
      p_hi_q <= {hx[23:0], 40'd0};
    end
    if (state_q == F_MODA) begin
      prod_q <= {33'd0, mod_v} * {32'd0, ModRecip};
    end
  end

endmodule

@@ src/phm_back.sv @@
// ----------------------------------------------------------------------------
// phm_back: table engine
// runs insert, find, remove and clear over the bucket and node memories
// ----------------------------------------------------------------------------
module phm_back #(
  parameter int unsigned Buckets    = phm_pkg::BucketsDef,
  parameter int unsigned Nodes      = phm_pkg::NodesDef,
  parameter int unsigned HandleBits = phm_pkg::HandleBitsDef,
  localparam int unsigned BW = (Buckets > 1) ? $clog2(Buckets) : 1,
  localparam int unsigned NW = $clog2(Nodes + 1),
  localparam int unsigned HB = (HandleBits < 32) ? HandleBits : 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_stall_o,
  input  phm_pkg::in_item_t q_item_i,
  input  logic [BW-1:0]     q_bucket_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output phm_pkg::out_item_t out_item_o
);

  localparam logic [NW-1:0] NullLink = NW'(Nodes);
  localparam int unsigned IW = (Nodes > 1) ? $clog2(Nodes) : 1;

  typedef enum logic [8:0] {
    B_INIT  = 9'b000000001,
    B_IDLE  = 9'b000000010,
    B_HEAD  = 9'b000000100,
    B_HWAIT = 9'b000001000,
    B_NODE  = 9'b000010000,
    B_NWAIT = 9'b000100000,
    B_CHECK = 9'b001000000,
    B_FIX   = 9'b010000000,
    B_OUT   = 9'b100000000
  } bstate_e;

  bstate_e state_q;

  logic [NW-1:0] heads_mem [Buckets];
  logic [63:0]   keys_mem  [Nodes];
  logic [HB-1:0] hnds_mem  [Nodes];
  logic [NW-1:0] links_mem [Nodes];

  phm_pkg::in_item_t item_q;
  logic [BW-1:0] bkt_q;
  logic [NW-1:0] free_q, cur_q, prev_q, head_rd_q, link_rd_q;
  logic [63:0]   key_rd_q;
  logic [HB-1:0] hnd_rd_q;
  logic [NW:0]   steps_q;
  // fill count: nodes at index >= fill_q were never handed out since clear
  logic [NW-1:0] fill_q;
  // bucket sweep pointer, used after reset and on clear
  logic [BW-1:0] init_q;
  phm_pkg::out_item_t res_q;
  logic          res_v_q;
  logic [HB-1:0] hnd_in;

  assign hnd_in      = q_item_i.handle[HB-1:0];
  assign q_stall_o   = (state_q != B_IDLE) || res_v_q;
  assign out_valid_o = res_v_q;
  assign out_item_o  = res_q;

  // free node lookup: if free list empty but fill not reached, take fill
  logic [NW-1:0] alloc;
  assign alloc = (free_q != NullLink) ? free_q : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_INIT;
      init_q  <= '0;
      free_q  <= NullLink;
      fill_q  <= '0;
      res_v_q <= 1'b0;
    end else begin
      if (res_v_q && !out_stall_i) res_v_q <= 1'b0;
      case (state_q)
        B_INIT: begin
          // sweep sets every bucket head to null
          if (init_q == BW'(Buckets - 1)) state_q <= B_IDLE;
          init_q <= init_q + 1'b1;
        end
        B_IDLE: begin
          if (q_valid_i && !res_v_q) begin
            item_q <= q_item_i;
            bkt_q  <= q_bucket_i;
            if (q_item_i.opcode == phm_pkg::OP_CLEAR) begin
              free_q  <= NullLink;
              fill_q  <= '0;
              init_q  <= '0;
              res_q   <= '{found: 1'b0, found_handle: '0, status: phm_pkg::ST_DONE};
              res_v_q <= 1'b1;
              state_q <= B_INIT;
            end else if (q_item_i.key_address == '0 ||
                         (q_item_i.opcode == phm_pkg::OP_INSERT && hnd_in == '0)) begin
              res_q   <= '{found: 1'b0, found_handle: '0, status: phm_pkg::ST_NULL};
              res_v_q <= 1'b1;
            end else if (q_item_i.opcode == phm_pkg::OP_INSERT &&
                         alloc == NullLink) begin
              res_q   <= '{found: 1'b0, found_handle: '0, status: phm_pkg::ST_FULL};
              res_v_q <= 1'b1;
            end else begin
              res_q   <= '{found: 1'b0, found_handle: '0, status: phm_pkg::ST_DONE};
              state_q <= B_HEAD;
            end
          end
        end
        B_HEAD: state_q <= B_HWAIT;
        B_HWAIT: begin
          if (item_q.opcode == phm_pkg::OP_INSERT) begin
            if (free_q != NullLink) free_q <= link_rd_q;
            else fill_q <= fill_q + 1'b1;
            res_v_q <= 1'b1;
            state_q <= B_IDLE;
          end else begin
            cur_q   <= head_rd_q;
            prev_q  <= NullLink;
            steps_q <= '0;
            state_q <= B_NODE;
          end
        end
        B_NODE: begin
          if (cur_q == NullLink || steps_q == (NW+1)'(Nodes)) begin
            res_v_q <= 1'b1;
            state_q <= B_IDLE;
          end else begin
            state_q <= B_NWAIT;
          end
        end
        B_NWAIT: state_q <= B_CHECK;
        B_CHECK: begin
          if (key_rd_q == item_q.key_address) begin
            if (item_q.opcode == phm_pkg::OP_FIND) begin
              res_q.found        <= 1'b1;
              res_q.found_handle <= 32'(hnd_rd_q);
              res_v_q            <= 1'b1;
              state_q            <= B_IDLE;
            end else begin
              state_q <= B_FIX;
            end
          end else begin
            prev_q  <= cur_q;
            cur_q   <= link_rd_q;
            steps_q <= steps_q + 1'b1;
            state_q <= B_NODE;
          end
        end
        B_FIX: begin
          free_q  <= cur_q;
          res_v_q <= 1'b1;
          state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (state_q == B_INIT) begin
      heads_mem[init_q] <= NullLink;
    end
    if (state_q == B_HEAD) begin
      head_rd_q <= heads_mem[bkt_q];
      link_rd_q <= links_mem[free_q[IW-1:0]];
    end
    if (state_q == B_NODE && cur_q != NullLink) begin
      key_rd_q  <= keys_mem[cur_q[IW-1:0]];
      hnd_rd_q  <= hnds_mem[cur_q[IW-1:0]];
      link_rd_q <= links_mem[cur_q[IW-1:0]];
    end
    if (state_q == B_HWAIT && item_q.opcode == phm_pkg::OP_INSERT) begin
      keys_mem[alloc[IW-1:0]]  <= item_q.key_address;
      hnds_mem[alloc[IW-1:0]]  <= item_q.handle[HB-1:0];
      links_mem[alloc[IW-1:0]] <= head_rd_q;
      heads_mem[bkt_q]         <= alloc;
    end
    if (state_q == B_CHECK && key_rd_q == item_q.key_address &&
        item_q.opcode == phm_pkg::OP_REMOVE) begin
      if (prev_q == NullLink) begin
        heads_mem[bkt_q] <= link_rd_q;
      end else begin
        links_mem[prev_q[IW-1:0]] <= link_rd_q;
      end
    end
    if (state_q == B_FIX) links_mem[cur_q[IW-1:0]] <= free_q;
  end

endmodule

@@ src/phm_queue.sv @@
// ----------------------------------------------------------------------------
// phm_queue: two-entry queue between front and back
// ----------------------------------------------------------------------------
module phm_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_stall_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_stall_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign wr_stall_o = (cnt_q == 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && !wr_stall_o;
  assign pop  = rd_valid_o && !rd_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

endmodule

@@ src/pointer_keyed_hash_map.sv @@
// ----------------------------------------------------------------------------
// pointer_keyed_hash_map: chained hash map from 64-bit addresses to handles
// fnv-1a bucket hash in a front end, chain engine over node memories in back
// ----------------------------------------------------------------------------
// results: clear and null or full status are answered straight from idle, insert
//   after a head read; find and remove walk the chain node by node, with an
//   extra step on a miss or on an unlink
// pacing: the front end takes a new input transfer only after it has pushed the
//   last one to the queue (accept, hash, bucket reduction, push); long chain walks
//   or a clear, which sweeps the bucket table, slow the flow further
// reset: after rst_ni rises the bucket table is swept, one entry per cycle,
//   during which no transfer is taken by the back end
module pointer_keyed_hash_map #(
  parameter int unsigned BUCKETS     = phm_pkg::BucketsDef,
  parameter int unsigned NODES       = phm_pkg::NodesDef,
  parameter int unsigned HANDLE_BITS = phm_pkg::HandleBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  phm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output phm_pkg::out_item_t out_item_o
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned QW = $bits(phm_pkg::in_item_t) + BW;

  // front to queue
  logic              f_valid, f_stall;
  phm_pkg::in_item_t f_item;
  logic [BW-1:0]     f_bucket;
  // queue to back
  logic              b_valid, b_stall;
  logic [QW-1:0]     b_data;
  phm_pkg::in_item_t b_item;
  logic [BW-1:0]     b_bucket;

  phm_front #(.Buckets(BUCKETS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_item_i,
    .q_valid_o (f_valid), .q_stall_i (f_stall),
    .q_item_o (f_item), .q_bucket_o (f_bucket)
  );

  phm_queue #(.Width(QW)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (f_valid), .wr_stall_o (f_stall),
    .wr_data_i ({f_item, f_bucket}),
    .rd_valid_o (b_valid), .rd_stall_i (b_stall), .rd_data_o (b_data)
  );

  // unpack queue word into item and bucket
  assign b_item   = b_data[QW-1:BW];
  assign b_bucket = b_data[BW-1:0];

  phm_back #(.Buckets(BUCKETS), .Nodes(NODES), .HandleBits(HANDLE_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i (b_valid), .q_stall_o (b_stall),
    .q_item_i (b_item), .q_bucket_i (b_bucket),
    .out_valid_o, .out_stall_i, .out_item_o
  );

endmodule

@@ src/phm_checker.sv @@
// ----------------------------------------------------------------------------
// phm_checker: port level checks for the hash map
// ----------------------------------------------------------------------------
module phm_port_checks (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input phm_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input phm_pkg::out_item_t out_item_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.found |-> out_item_o.status == phm_pkg::ST_DONE)
    else $error("found with bad status");

  a_no_status3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status != phm_pkg::ST_UNUSED)
    else $error("reserved status");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |-> out_item_o.found_handle == '0)
    else $error("handle without match");

endmodule

bind pointer_keyed_hash_map phm_port_checks u_phm_checker (.*);
